// ----- rtl/core/rrhl_pkg.sv -----
// ----------------------------------------------------------------------------
// Round-robin handle list package
// Shared constants, opcodes, command type and sequencer states.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rrhl_pkg;

  // Fixed field widths of the ports.
  localparam int OP_W     = 3;
  localparam int HANDLE_W = 32;
  localparam int COUNT_W  = 5;

  // Opcodes carried on op_i.
  localparam logic [OP_W-1:0] OP_APPEND = 3'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 3'd1;
  localparam logic [OP_W-1:0] OP_POP    = 3'd2;
  localparam logic [OP_W-1:0] OP_NEXT   = 3'd3;
  localparam logic [OP_W-1:0] OP_FIND   = 3'd4;

  // Command queue between the front end and the executor.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Decoded operation kind; unknown opcodes become a no-op.
  typedef enum logic [2:0] {
    K_APPEND = 3'd0,
    K_REMOVE = 3'd1,
    K_POP    = 3'd2,
    K_NEXT   = 3'd3,
    K_FIND   = 3'd4,
    K_NOP    = 3'd5
  } kind_e;

  // One classified command as it travels through the queue.
  typedef struct packed {
    kind_e               kind;
    logic                hnull;
    logic [HANDLE_W-1:0] handle;
  } cmd_t;

  // Executor sequencer states.
  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_LOAD  = 7'b0000010,
    S_CMP   = 7'b0000100,
    S_SH_RD = 7'b0001000,
    S_SH_WR = 7'b0010000,
    S_FIX   = 7'b0100000,
    S_RESP  = 7'b1000000
  } state_e;

endpackage

// ----- rtl/core/rrhl_front.sv -----
// ----------------------------------------------------------------------------
// Round-robin handle list front end
// Accepts input transactions, decodes the opcode and masks the handle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rrhl_front import rrhl_pkg::*; #(
  parameter int HANDLE_BITS = 32
) (
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [OP_W-1:0]     op_i,
  input  logic [HANDLE_W-1:0] handle_i,
  input  logic                q_full_i,
  output logic                push_o,
  output cmd_t                cmd_o
);

  localparam int STORE_BITS = (HANDLE_BITS < HANDLE_W) ? HANDLE_BITS : HANDLE_W;
  localparam logic [HANDLE_W-1:0] HANDLE_MASK =
    HANDLE_W'((65'd1 << STORE_BITS) - 65'd1);

  logic [HANDLE_W-1:0] handle_m;

  // Room in the queue is the only thing that holds off a new transaction.
  assign in_ready_o = !q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  // Only the low handle bits take part; a masked zero is a null handle.
  assign handle_m = handle_i & HANDLE_MASK;

  // Classify the transaction.
  always_comb begin
    cmd_o.handle = handle_m;
    cmd_o.hnull  = (handle_m == '0);
    case (op_i)
      OP_APPEND: cmd_o.kind = K_APPEND;
      OP_REMOVE: cmd_o.kind = K_REMOVE;
      OP_POP:    cmd_o.kind = K_POP;
      OP_NEXT:   cmd_o.kind = K_NEXT;
      OP_FIND:   cmd_o.kind = K_FIND;
      default:   cmd_o.kind = K_NOP;
    endcase
  end

endmodule

// ----- rtl/core/rrhl_queue.sv -----
// ----------------------------------------------------------------------------
// Round-robin handle list command queue
// Short FIFO that decouples the front end from the executor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rrhl_queue import rrhl_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  input  logic pop_i,
  output logic full_o,
  output logic empty_o,
  output cmd_t cmd_o
);

  cmd_t              slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign cmd_o   = slot_q[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage slots need no reset.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

// ----- rtl/core/rrhl_back.sv -----
// ----------------------------------------------------------------------------
// Round-robin handle list executor
// Holds the entry memory, count and cursor, and sequences each command.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rrhl_back import rrhl_pkg::*; #(
  parameter int CAPACITY   = 16,
  parameter int STORE_BITS = 32,
  parameter int IDX_W      = $clog2(CAPACITY),
  parameter int CNT_W      = $clog2(CAPACITY + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_empty_i,
  input  cmd_t                q_cmd_i,
  output logic                q_pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                ok_o,
  output logic [HANDLE_W-1:0] data_o,
  output logic [COUNT_W-1:0]  count_o,
  output logic [CNT_W-1:0]    list_count_o,
  output logic [IDX_W-1:0]    cursor_o
);

  // Entry memory with one write and one registered read port.
  logic [STORE_BITS-1:0] mem_q [CAPACITY];
  logic [STORE_BITS-1:0] rd_data_q;
  logic                  mem_we, mem_re;
  logic [IDX_W-1:0]      mem_waddr, mem_raddr;
  logic [STORE_BITS-1:0] mem_wdata;

  state_e                state_q, state_d;
  cmd_t                  cmd_q, cmd_d;
  logic [IDX_W-1:0]      idx_q, idx_d;
  logic [IDX_W-1:0]      pos_q, pos_d;
  logic [IDX_W-1:0]      cur_q, cur_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic                  res_ok_q, res_ok_d;
  logic [STORE_BITS-1:0] res_data_q, res_data_d;
  logic                  out_valid_q, out_valid_d;
  logic                  out_ok_q, out_ok_d;
  logic [STORE_BITS-1:0] out_data_q, out_data_d;
  logic [CNT_W-1:0]      out_cnt_q, out_cnt_d;

  logic [CNT_W-1:0]      idx_inc;
  logic [CNT_W-1:0]      cur_ext;
  logic [CNT_W-1:0]      cnt_dec;
  logic [STORE_BITS-1:0] cmd_h;

  assign idx_inc = CNT_W'(idx_q) + CNT_W'(1);
  assign cur_ext = CNT_W'(cur_q);
  assign cnt_dec = cnt_q - CNT_W'(1);
  assign cmd_h   = cmd_q.handle[STORE_BITS-1:0];

  // Command sequencer: append, search, shift-down delete, round-robin next and cursor fix-up.
  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    idx_d       = idx_q;
    pos_d       = pos_q;
    cur_d       = cur_q;
    cnt_d       = cnt_q;
    res_ok_d    = res_ok_q;
    res_data_d  = res_data_q;
    out_ok_d    = out_ok_q;
    out_data_d  = out_data_q;
    out_cnt_d   = out_cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    q_pop_o     = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = idx_q;
    mem_wdata   = rd_data_q;
    mem_re      = 1'b0;
    mem_raddr   = idx_q;

    case (state_q)
      S_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o    = 1'b1;
          cmd_d      = q_cmd_i;
          res_ok_d   = 1'b0;
          res_data_d = '0;
          state_d    = S_RESP;
          case (q_cmd_i.kind)
            K_APPEND: begin
              if (!q_cmd_i.hnull && cnt_q != CNT_W'(CAPACITY)) begin
                mem_we    = 1'b1;
                mem_waddr = cnt_q[IDX_W-1:0];
                mem_wdata = q_cmd_i.handle[STORE_BITS-1:0];
                cnt_d     = cnt_q + CNT_W'(1);
                res_ok_d  = 1'b1;
                if (cnt_q == '0) begin
                  cur_d = '0;
                end
              end
            end
            K_REMOVE, K_FIND: begin
              if (!q_cmd_i.hnull && cnt_q != '0) begin
                idx_d   = '0;
                state_d = S_LOAD;
              end
            end
            K_POP: begin
              if (cnt_q != '0) begin
                idx_d   = '0;
                state_d = S_LOAD;
              end
            end
            K_NEXT: begin
              if (cnt_q != '0) begin
                if (cur_ext >= cnt_q) begin
                  idx_d = '0;
                  cur_d = '0;
                end else begin
                  idx_d = cur_q;
                end
                state_d = S_LOAD;
              end
            end
            default: ;
          endcase
        end
      end

      S_LOAD: begin
        mem_re    = 1'b1;
        mem_raddr = idx_q;
        state_d   = S_CMP;
      end

      S_CMP: begin
        case (cmd_q.kind)
          K_REMOVE, K_FIND: begin
            if (rd_data_q == cmd_h) begin
              res_ok_d = 1'b1;
              if (cmd_q.kind == K_FIND) begin
                res_data_d = rd_data_q;
                state_d    = S_RESP;
              end else begin
                pos_d   = idx_q;
                state_d = (idx_inc < cnt_q) ? S_SH_RD : S_FIX;
              end
            end else if (idx_inc >= cnt_q) begin
              state_d = S_RESP;
            end else begin
              idx_d   = idx_q + 1'b1;
              state_d = S_LOAD;
            end
          end
          K_POP: begin
            res_ok_d   = 1'b1;
            res_data_d = rd_data_q;
            pos_d      = idx_q;
            state_d    = (idx_inc < cnt_q) ? S_SH_RD : S_FIX;
          end
          K_NEXT: begin
            res_ok_d   = 1'b1;
            res_data_d = rd_data_q;
            cur_d      = ((cur_ext + CNT_W'(1)) >= cnt_q) ? '0 : cur_q + 1'b1;
            state_d    = S_RESP;
          end
          default: state_d = S_RESP;
        endcase
      end

      // Move the following entry down by one place.
      S_SH_RD: begin
        mem_re    = 1'b1;
        mem_raddr = idx_inc[IDX_W-1:0];
        state_d   = S_SH_WR;
      end

      S_SH_WR: begin
        mem_we    = 1'b1;
        mem_waddr = idx_q;
        mem_wdata = rd_data_q;
        idx_d     = idx_q + 1'b1;
        state_d   = ((idx_inc + CNT_W'(1)) < cnt_q) ? S_SH_RD : S_FIX;
      end

      // Shrink the list and keep the cursor on its entry, or on the next one.
      S_FIX: begin
        cnt_d = cnt_dec;
        if (cnt_dec == '0) begin
          cur_d = '0;
        end else if (cur_q > pos_q) begin
          cur_d = cur_q - 1'b1;
        end else if (cur_q == pos_q && cur_ext >= cnt_dec) begin
          cur_d = '0;
        end
        state_d = S_RESP;
      end

      S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_ok_d    = res_ok_q;
          out_data_d  = res_data_q;
          out_cnt_d   = cnt_q;
          state_d     = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      cur_q       <= '0;
      idx_q       <= '0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      cur_q       <= cur_d;
      idx_q       <= idx_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    res_ok_q   <= res_ok_d;
    res_data_q <= res_data_d;
    out_ok_q   <= out_ok_d;
    out_data_q <= out_data_d;
    out_cnt_q  <= out_cnt_d;
  end

  // Entry memory write port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
  end

  // Entry memory registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      rd_data_q <= mem_q[mem_raddr];
    end
  end

  assign out_valid_o  = out_valid_q;
  assign ok_o         = out_ok_q;
  assign data_o       = HANDLE_W'(out_data_q);
  assign count_o      = COUNT_W'(out_cnt_q);
  assign list_count_o = cnt_q;
  assign cursor_o     = cur_q;

endmodule

// ----- rtl/core/round_robin_handle_list.sv -----
// Append and a transaction turned away up front (null handle, empty or full list,
// unknown op) go straight to the response; next reads the entry at the cursor; find
// and remove compare entries in order from the head; pop and a remove that hits shift
// the later entries down, then fix the cursor. The executor runs one transaction at a
// time, working on one entry memory port at a time; the command queue takes new
// transactions while it is busy. Reset clears count, cursor, queue and output; entry memory is not cleared.
// ----------------------------------------------------------------------------
// Round-robin handle list
// Ordered list of nonzero handles with a circular round-robin cursor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module round_robin_handle_list import rrhl_pkg::*; #(
  parameter int CAPACITY    = 16,
  parameter int HANDLE_BITS = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [OP_W-1:0]     op_i,
  input  logic [HANDLE_W-1:0] handle_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                ok_o,
  output logic [HANDLE_W-1:0] data_o,
  output logic [COUNT_W-1:0]  count_o
);

  localparam int STORE_BITS = (HANDLE_BITS < HANDLE_W) ? HANDLE_BITS : HANDLE_W;
  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);

  logic             push;
  logic             q_full;
  logic             q_empty;
  logic             q_pop;
  cmd_t             front_cmd;
  cmd_t             q_cmd;
  logic [CNT_W-1:0] list_count;
  logic [IDX_W-1:0] cursor;

  // Front end: accept and classify.
  rrhl_front #(
    .HANDLE_BITS (HANDLE_BITS)
  ) u_front (
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .op_i       (op_i),
    .handle_i   (handle_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .cmd_o      (front_cmd)
  );

  // Command queue.
  rrhl_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (front_cmd),
    .pop_i   (q_pop),
    .full_o  (q_full),
    .empty_o (q_empty),
    .cmd_o   (q_cmd)
  );

  // Executor.
  rrhl_back #(
    .CAPACITY   (CAPACITY),
    .STORE_BITS (STORE_BITS),
    .IDX_W      (IDX_W),
    .CNT_W      (CNT_W)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_empty_i    (q_empty),
    .q_cmd_i      (q_cmd),
    .q_pop_o      (q_pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .ok_o         (ok_o),
    .data_o       (data_o),
    .count_o      (count_o),
    .list_count_o (list_count),
    .cursor_o     (cursor)
  );

  // The entry count never exceeds the table size.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    list_count <= CNT_W'(CAPACITY))
    else $error("entry count exceeds capacity");

  // An empty list keeps the cursor at the head.
  a_cursor_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (list_count == '0) |-> (cursor == '0))
    else $error("cursor not at head on empty list");

  // A nonempty list keeps the cursor on a held entry.
  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (list_count != '0) |-> (CNT_W'(cursor) < list_count))
    else $error("cursor beyond last entry");

endmodule
